>>> rtl/core/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types and constants for the differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam int unsigned STICK_W   = 8;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned DBAND_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  localparam logic [STICK_W-1:0] STICK_CENTER = 8'd127;
  localparam logic [DUTY_W-1:0]  DUTY_MAX     = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MS = 1'b1;

  localparam logic [DBAND_W-1:0] DEADBAND_RST  = 7'd10;
  localparam logic [MS_W-1:0]    CUTOFF_MS_RST = 16'd1000;

  typedef logic [STICK_W-1:0] stick_t;
  typedef logic [DUTY_W-1:0]  duty_t;

  typedef struct packed {
    logic [DBAND_W-1:0] deadband;
    logic [MS_W-1:0]    cutoff_ms;
  } ddm_cfg_t;

  typedef struct packed {
    duty_t left_fwd;
    duty_t left_rev;
    duty_t right_fwd;
    duty_t right_rev;
    logic  link_lost;
  } ddm_result_t;

endpackage

>>> rtl/core/ddm_mag.sv
// ----------------------------------------------------------------------------
// ddm_mag
// Stick byte to magnitude: min(|x-127|*255/127, 255).
// ----------------------------------------------------------------------------
module ddm_mag (
  input  ddm_pkg::stick_t stick,
  output ddm_pkg::duty_t  mag
);
  import ddm_pkg::*;

  logic [STICK_W-1:0] delta;

  // d*255/127 = 2d + d/127; for d <= 128 that is 2d below 127, and the
  // clamp covers 127 and 128.
  always_comb begin
    if (stick >= STICK_CENTER) begin
      delta = stick - STICK_CENTER;
    end else begin
      delta = STICK_CENTER - stick;
    end
    if (delta >= STICK_CENTER) begin
      mag = DUTY_MAX;
    end else begin
      mag = {delta[DUTY_W-2:0], 1'b0};
    end
  end

endmodule

>>> rtl/core/ddm_mix.sv
// ----------------------------------------------------------------------------
// ddm_mix
// Combinational arcade mix: timeout, pivot, cut and boost of each side.
// ----------------------------------------------------------------------------
module ddm_mix (
  input  ddm_pkg::stick_t            throttle,
  input  ddm_pkg::stick_t            steer,
  input  logic [ddm_pkg::MS_W-1:0]   elapsed_ms,
  input  ddm_pkg::ddm_cfg_t          cfg,
  output ddm_pkg::ddm_result_t       res
);
  import ddm_pkg::*;

  duty_t            mag_thr;
  duty_t            mag_str;
  duty_t            cut_v;
  logic [DUTY_W:0]  boost_sum;
  duty_t            boost_v;
  duty_t            l_v;
  duty_t            r_v;
  logic [STICK_W:0] thr_hi;
  logic [STICK_W:0] ctr_hi;
  logic             pivot;
  logic             fwd;

  ddm_mag u_mag_thr (.stick(throttle), .mag(mag_thr));
  ddm_mag u_mag_str (.stick(steer),    .mag(mag_str));

  always_comb begin
    cut_v     = (mag_thr < mag_str) ? '0 : (mag_thr - mag_str);
    boost_sum = {1'b0, mag_thr} + {1'b0, mag_str};
    boost_v   = boost_sum[DUTY_W] ? DUTY_MAX : boost_sum[DUTY_W-1:0];

    thr_hi = {1'b0, throttle} + {{(STICK_W+1-DBAND_W){1'b0}}, cfg.deadband};
    ctr_hi = {1'b0, STICK_CENTER} + {{(STICK_W+1-DBAND_W){1'b0}}, cfg.deadband};
    pivot  = (thr_hi >= {1'b0, STICK_CENTER}) && ({1'b0, throttle} <= ctr_hi);
    fwd    = throttle > STICK_CENTER;

    l_v = mag_thr;
    r_v = mag_thr;
    if (steer > STICK_CENTER) begin
      l_v = cut_v;
      if (fwd) begin
        r_v = boost_v;
      end
    end else if (steer < STICK_CENTER) begin
      r_v = cut_v;
      if (fwd) begin
        l_v = boost_v;
      end
    end

    res = '0;
    if (elapsed_ms > cfg.cutoff_ms) begin
      res.link_lost = 1'b1;
    end else if (pivot) begin
      if (steer < STICK_CENTER) begin
        res.left_fwd = mag_str;
      end else begin
        res.right_fwd = mag_str;
      end
    end else if (fwd) begin
      res.left_fwd  = l_v;
      res.right_fwd = r_v;
    end else begin
      res.left_rev  = l_v;
      res.right_rev = r_v;
    end
  end

endmodule

>>> rtl/core/differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Arcade-style stick mixing into forward/reverse PWM duties for a
// skid-steer base, with a radio link timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_throttle, in_steer and in_elapsed_ms with start
//   high; the transfer happens at the rising edge where busy is low. busy is
//   always low, so one sample can be transferred in every cycle.
//   Result channel: out_valid marks one cycle in which the four duties and
//   out_link_lost hold the result; the receiver takes it at the edge that
//   ends that cycle and cannot stall the block.
//   Path: the input register takes the sample at the transfer edge, and
//   the mix logic feeds the result register, which drives the ports.
//   Throughput: one sample per cycle; set by the single register-to-register
//   mix path.
//   Config: cfg_we writes deadband (index 0, bits 6:0) or cutoff_ms
//   (index 1, bits 15:0) at the clock edge. Write only while idle.
//   Reset: synchronous, active low rst_n; clears the valid pipeline and
//   loads deadband = 10 and cutoff_ms = 1000. No result is lost or made up
//   by reset beyond dropping items in flight.
// ----------------------------------------------------------------------------
module differential_drive_mixer (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           start,
  output logic                           busy,
  input  ddm_pkg::stick_t                in_throttle,
  input  ddm_pkg::stick_t                in_steer,
  input  logic [ddm_pkg::MS_W-1:0]       in_elapsed_ms,
  // result channel
  output logic                           out_valid,
  output ddm_pkg::duty_t                 out_left_fwd_duty,
  output ddm_pkg::duty_t                 out_left_rev_duty,
  output ddm_pkg::duty_t                 out_right_fwd_duty,
  output ddm_pkg::duty_t                 out_right_rev_duty,
  output logic                           out_link_lost,
  // configuration port
  input  logic                           cfg_we,
  input  logic [ddm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddm_pkg::CFG_W-1:0]      cfg_wdata
);
  import ddm_pkg::*;

  ddm_cfg_t    cfg_r;
  // input register stage
  logic        in_vld_r;
  stick_t      thr_r;
  stick_t      str_r;
  logic [MS_W-1:0] el_r;
  // result register stage
  logic        out_vld_r;
  ddm_result_t res_r;
  ddm_result_t res_nxt;

  // Fully pipelined: never refuses a transfer.
  assign busy = 1'b0;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband  <= DEADBAND_RST;
      cfg_r.cutoff_ms <= CUTOFF_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADBAND:  cfg_r.deadband  <= cfg_wdata[DBAND_W-1:0];
        REG_CUTOFF_MS: cfg_r.cutoff_ms <= cfg_wdata[MS_W-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  // Valid pipeline (control, reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  // Payload registers (no reset)
  always_ff @(posedge clk) begin
    if (start) begin
      thr_r <= in_throttle;
      str_r <= in_steer;
      el_r  <= in_elapsed_ms;
    end
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  ddm_mix u_mix (
    .throttle   (thr_r),
    .steer      (str_r),
    .elapsed_ms (el_r),
    .cfg        (cfg_r),
    .res        (res_nxt)
  );

  assign out_valid          = out_vld_r;
  assign out_left_fwd_duty  = res_r.left_fwd;
  assign out_left_rev_duty  = res_r.left_rev;
  assign out_right_fwd_duty = res_r.right_fwd;
  assign out_right_rev_duty = res_r.right_rev;
  assign out_link_lost      = res_r.link_lost;

endmodule
